// ===== src/ufrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufrb_pkg
// Shared types, register codes and helper functions for the UART register
// block with transmit and receive byte FIFOs.
// ----------------------------------------------------------------------------
package ufrb_pkg;

    // FIFO sizes and reset value of the divisor.
    localparam int          TX_DEPTH  = 8;
    localparam int          RX_DEPTH  = 8;
    localparam logic [15:0] DIV_RESET = 16'd868;

    // Pointer and count widths follow from the FIFO depths.
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Width used to compare FIFO counts against watermarks.
    localparam int WM_CMP_W = 8;

    // Packed control register: enable, nstop, three watermark bits.
    localparam int CTRL_W = 5;

    // Input function codes.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RECV  = 2'd2;

    // Classified operations handed to the back end.
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_RECV  = 2'd3;

    // Word register indexes.
    localparam logic [2:0] REG_TXDATA = 3'd0;
    localparam logic [2:0] REG_RXDATA = 3'd1;
    localparam logic [2:0] REG_TXCTRL = 3'd2;
    localparam logic [2:0] REG_RXCTRL = 3'd3;
    localparam logic [2:0] REG_IE     = 3'd4;
    localparam logic [2:0] REG_IP     = 3'd5;
    localparam logic [2:0] REG_DIV    = 3'd6;

    // Result kinds.
    localparam logic KIND_RESP = 1'b0;
    localparam logic KIND_TX   = 1'b1;

    // Flag in bit 31 of txdata (full) and rxdata (empty) reads.
    localparam logic [31:0] BUS_FLAG = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] read_data;
        logic [7:0]  tx_byte;
        logic        tx_irq;
        logic        rx_irq;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  reg_index;
        logic [31:0] data;
    } cmd_t;

    // Control register as it appears on the bus.
    function automatic logic [31:0] ctrl_to_bus(input logic [CTRL_W-1:0] c);
        return {13'd0, c[4:2], 14'd0, c[1:0]};
    endfunction

    // Bus value to packed control register.
    function automatic logic [CTRL_W-1:0] bus_to_ctrl(input logic [31:0] v);
        return {v[18:16], v[1:0]};
    endfunction

    // Watermark pending bits: bit 0 transmit, bit 1 receive.
    function automatic logic [1:0] irq_pending(input logic [TX_CNT_W-1:0] tx_cnt,
                                               input logic [RX_CNT_W-1:0] rx_cnt,
                                               input logic [CTRL_W-1:0]   tx_ctl,
                                               input logic [CTRL_W-1:0]   rx_ctl);
        logic [WM_CMP_W-1:0] tx_c;
        logic [WM_CMP_W-1:0] rx_c;
        logic [WM_CMP_W-1:0] tx_w;
        logic [WM_CMP_W-1:0] rx_w;
        tx_c = WM_CMP_W'(tx_cnt);
        rx_c = WM_CMP_W'(rx_cnt);
        tx_w = WM_CMP_W'(tx_ctl[4:2]);
        rx_w = WM_CMP_W'(rx_ctl[4:2]);
        return {(rx_c > rx_w), (tx_c < tx_w)};
    endfunction

    // Circular pointer steps with wrap at the depth.
    function automatic logic [TX_PTR_W-1:0] tx_ptr_inc(input logic [TX_PTR_W-1:0] p);
        return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + TX_PTR_W'(1);
    endfunction

    function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
        return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + RX_PTR_W'(1);
    endfunction

    function automatic logic [Q_PTR_W-1:0] q_ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

endpackage

// ===== src/ufrb_front.sv =====
// ----------------------------------------------------------------------------
// ufrb_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module ufrb_front (
    input  logic           req_valid,
    output logic           req_stall,
    input  ufrb_pkg::item_t req,
    output logic           cmd_valid,
    input  logic           cmd_stall,
    output ufrb_pkg::cmd_t cmd
);
    import ufrb_pkg::*;

    logic [1:0] op;

    // Map the function code to an operation; the unused code does nothing.
    always_comb
    begin
        unique case (req.func)
            FUNC_READ:  op = OP_READ;
            FUNC_WRITE: op = OP_WRITE;
            FUNC_RECV:  op = OP_RECV;
            default:    op = OP_NOP;
        endcase
    end

    // A received byte travels in the low bits of the data word.
    always_comb
    begin
        cmd.op        = op;
        cmd.reg_index = req.reg_index;
        cmd.data      = (op == OP_RECV) ? {24'd0, req.rx_byte} : req.write_data;
    end

    assign cmd_valid = req_valid;
    assign req_stall = cmd_stall;

endmodule

// ===== src/ufrb_queue.sv =====
// ----------------------------------------------------------------------------
// ufrb_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ufrb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_stall,
    input  ufrb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_stall,
    output ufrb_pkg::cmd_t pop_cmd
);
    import ufrb_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push_ok;
    logic               pop_ok;

    assign push_stall = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push_ok    = push_valid && !push_stall;
    assign pop_ok     = pop_valid && !pop_stall;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = push_ok ? q_ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? q_ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/ufrb_back.sv =====
// ----------------------------------------------------------------------------
// ufrb_back
// Carries out commands: register file, transmit and receive FIFOs, the
// transmit drain sequence and the result register.
// ----------------------------------------------------------------------------
module ufrb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ufrb_pkg::cmd_t    cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ufrb_pkg::result_t rsp
);
    import ufrb_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;

    // FIFO storage and pointers.
    logic [7:0]          tx_store_reg [TX_DEPTH];
    logic [7:0]          rx_store_reg [RX_DEPTH];
    logic [TX_PTR_W-1:0] tx_head_reg;
    logic [TX_PTR_W-1:0] tx_head_next;
    logic [TX_PTR_W-1:0] tx_tail_reg;
    logic [TX_PTR_W-1:0] tx_tail_next;
    logic [TX_CNT_W-1:0] tx_count_reg;
    logic [TX_CNT_W-1:0] tx_count_next;
    logic [RX_PTR_W-1:0] rx_head_reg;
    logic [RX_PTR_W-1:0] rx_head_next;
    logic [RX_PTR_W-1:0] rx_tail_reg;
    logic [RX_PTR_W-1:0] rx_tail_next;
    logic [RX_CNT_W-1:0] rx_count_reg;
    logic [RX_CNT_W-1:0] rx_count_next;

    // Configuration registers.
    logic [CTRL_W-1:0]   tx_ctrl_reg;
    logic [CTRL_W-1:0]   tx_ctrl_next;
    logic [CTRL_W-1:0]   rx_ctrl_reg;
    logic [CTRL_W-1:0]   rx_ctrl_next;
    logic [1:0]          ie_reg;
    logic [1:0]          ie_next;
    logic [15:0]         div_reg;
    logic [15:0]         div_next;

    // Result register.
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    result_t             rsp_reg;
    result_t             rsp_next;

    logic                out_free;
    logic                take;
    logic                is_read;
    logic                is_write;
    logic                is_recv;
    logic                tx_full;
    logic                tx_push;
    logic                rx_push;
    logic                rx_pop;
    logic                drain_req;
    logic [TX_CNT_W-1:0] tx_count_new;
    logic [RX_CNT_W-1:0] rx_count_new;
    logic [CTRL_W-1:0]   tx_ctrl_new;
    logic [CTRL_W-1:0]   rx_ctrl_new;
    logic [1:0]          ie_new;
    logic [31:0]         rd;
    logic [TX_CNT_W-1:0] tx_count_dec;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign take      = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Classify the command at the head of the queue.
    assign is_read  = (cmd.op == OP_READ);
    assign is_write = (cmd.op == OP_WRITE);
    assign is_recv  = (cmd.op == OP_RECV);
    assign tx_full  = (tx_count_reg == TX_CNT_W'(TX_DEPTH));
    assign tx_push  = is_write && (cmd.reg_index == REG_TXDATA) && !tx_full;
    assign rx_push  = is_recv && rx_ctrl_reg[0] && (rx_count_reg != RX_CNT_W'(RX_DEPTH));
    assign rx_pop   = is_read && (cmd.reg_index == REG_RXDATA) && rx_ctrl_reg[0]
                      && (rx_count_reg != '0);

    // State as it stands once the command has been applied.
    always_comb
    begin
        tx_count_new = tx_push ? tx_count_reg + TX_CNT_W'(1) : tx_count_reg;
        rx_count_new = rx_count_reg;
        if (rx_push)
        begin
            rx_count_new = rx_count_reg + RX_CNT_W'(1);
        end
        else if (rx_pop)
        begin
            rx_count_new = rx_count_reg - RX_CNT_W'(1);
        end
        tx_ctrl_new = (is_write && (cmd.reg_index == REG_TXCTRL))
                      ? bus_to_ctrl(cmd.data) : tx_ctrl_reg;
        rx_ctrl_new = (is_write && (cmd.reg_index == REG_RXCTRL))
                      ? bus_to_ctrl(cmd.data) : rx_ctrl_reg;
        ie_new      = (is_write && (cmd.reg_index == REG_IE)) ? cmd.data[1:0] : ie_reg;
        drain_req   = is_write
                      && ((cmd.reg_index == REG_TXDATA) || (cmd.reg_index == REG_TXCTRL))
                      && tx_ctrl_new[0] && (tx_count_new != '0);
    end

    // Bus read data, taken from the state before the command.
    always_comb
    begin
        rd = '0;
        if (is_read)
        begin
            unique case (cmd.reg_index)
                REG_TXDATA: rd = tx_full ? BUS_FLAG : 32'd0;
                REG_RXDATA: rd = rx_pop ? {24'd0, rx_store_reg[rx_head_reg]} : BUS_FLAG;
                REG_TXCTRL: rd = ctrl_to_bus(tx_ctrl_reg);
                REG_RXCTRL: rd = ctrl_to_bus(rx_ctrl_reg);
                REG_IE:     rd = {30'd0, ie_reg};
                REG_IP:     rd = {30'd0, irq_pending(tx_count_reg, rx_count_reg,
                                                     tx_ctrl_reg, rx_ctrl_reg)};
                REG_DIV:    rd = {16'd0, div_reg};
                default:    rd = 32'd0;
            endcase
        end
    end

    assign tx_count_dec = tx_count_reg - TX_CNT_W'(1);

    // Sequencer: apply a command, drain transmit bytes, send the response.
    always_comb
    begin
        state_next     = state_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_count_next  = tx_count_reg;
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_count_next  = rx_count_reg;
        tx_ctrl_next   = tx_ctrl_reg;
        rx_ctrl_next   = rx_ctrl_reg;
        ie_next        = ie_reg;
        div_next       = div_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    tx_count_next = tx_count_new;
                    rx_count_next = rx_count_new;
                    tx_ctrl_next  = tx_ctrl_new;
                    rx_ctrl_next  = rx_ctrl_new;
                    ie_next       = ie_new;
                    if (tx_push)
                    begin
                        tx_tail_next = tx_ptr_inc(tx_tail_reg);
                    end
                    if (rx_push)
                    begin
                        rx_tail_next = rx_ptr_inc(rx_tail_reg);
                    end
                    if (rx_pop)
                    begin
                        rx_head_next = rx_ptr_inc(rx_head_reg);
                    end
                    if (is_write && (cmd.reg_index == REG_DIV))
                    begin
                        div_next = cmd.data[15:0];
                    end
                    if (drain_req)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        rsp_valid_next     = 1'b1;
                        rsp_next.kind      = KIND_RESP;
                        rsp_next.read_data = rd;
                        rsp_next.tx_byte   = 8'd0;
                        {rsp_next.rx_irq, rsp_next.tx_irq} =
                            irq_pending(tx_count_new, rx_count_new, tx_ctrl_new, rx_ctrl_new)
                            & ie_new;
                        rsp_next.last      = 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    tx_head_next       = tx_ptr_inc(tx_head_reg);
                    tx_count_next      = tx_count_dec;
                    rsp_valid_next     = 1'b1;
                    rsp_next.kind      = KIND_TX;
                    rsp_next.read_data = 32'd0;
                    rsp_next.tx_byte   = tx_store_reg[tx_head_reg];
                    {rsp_next.rx_irq, rsp_next.tx_irq} =
                        irq_pending(tx_count_dec, rx_count_reg, tx_ctrl_reg, rx_ctrl_reg)
                        & ie_reg;
                    rsp_next.last      = 1'b0;
                    if (tx_count_dec == '0)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.kind      = KIND_RESP;
                    rsp_next.read_data = 32'd0;
                    rsp_next.tx_byte   = 8'd0;
                    {rsp_next.rx_irq, rsp_next.tx_irq} =
                        irq_pending(tx_count_reg, rx_count_reg, tx_ctrl_reg, rx_ctrl_reg)
                        & ie_reg;
                    rsp_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_count_reg  <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_count_reg  <= '0;
            tx_ctrl_reg   <= '0;
            rx_ctrl_reg   <= '0;
            ie_reg        <= '0;
            div_reg       <= DIV_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_count_reg  <= tx_count_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_count_reg  <= rx_count_next;
            tx_ctrl_reg   <= tx_ctrl_next;
            rx_ctrl_reg   <= rx_ctrl_next;
            ie_reg        <= ie_next;
            div_reg       <= div_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload and FIFO storage.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (take && tx_push)
        begin
            tx_store_reg[tx_tail_reg] <= cmd.data[7:0];
        end
        if (take && rx_push)
        begin
            rx_store_reg[rx_tail_reg] <= cmd.data[7:0];
        end
    end

endmodule

// ===== src/uart_fifo_register_block_core.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_register_block_core
// Register view of a UART with transmit and receive byte FIFOs.
// ----------------------------------------------------------------------------
// Each item is a bus read, a bus write or a received serial byte. Every item
// produces one access response (last set); a transmit data or transmit
// control write with transmit enabled first produces one result per byte
// drained from the transmit FIFO, in FIFO order. An item passes the front
// end and a two-entry command queue; once the back end takes it, its
// response is registered in the result register. With the result side free
// and no drain in progress, the back end takes one item per cycle. A write
// that drains the transmit FIFO holds the back end while it applies the
// write, emits one result per transmitted byte and then sends the response;
// a stall on the result side holds each of these steps.
module uart_fifo_register_block_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ufrb_pkg::item_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ufrb_pkg::result_t rsp
);
    import ufrb_pkg::*;

    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic q_valid;
    logic q_stall;
    cmd_t q_cmd;

    // Accept and classify.
    ufrb_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    // Decoupling queue.
    ufrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_stall (cmd_stall),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_cmd    (q_cmd)
    );

    // Execute and emit results.
    ufrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_stall (q_stall),
        .cmd       (q_cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
